[rtl/core/piecewise_linear_calibration_assert.svh]
// Assertion helpers shared by the calibration block.
// Every check is clocked on clk and is switched off while rst_n is low.
`ifndef PIECEWISE_LINEAR_CALIBRATION_ASSERT_SVH
`define PIECEWISE_LINEAR_CALIBRATION_ASSERT_SVH

// A property that must hold at every clock edge out of reset.
`define PLC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// A condition that must never be seen out of reset.
`define PLC_NEVER(lbl, expr, msg) \
  `PLC_ASSERT(lbl, !(expr), msg)

`endif

[rtl/core/plc_pkg.sv]
package plc_pkg;

  // Number of calibration points in the table.
  localparam int TABLE_POINTS = 14;
  localparam int PIDX_W       = $clog2(TABLE_POINTS);
  localparam int CNT_W        = $clog2(TABLE_POINTS + 1);

  localparam int DATA_W   = 12;
  localparam int IDX_W    = 4;
  localparam int POINT_W  = 2 * DATA_W;
  localparam int PROD_W   = 2 * DATA_W;

  // One quotient bit per divider step.
  localparam int DIV_STEPS = DATA_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  // Request opcodes.
  localparam logic [1:0] OP_TO_MV   = 2'd0;
  localparam logic [1:0] OP_TO_CODE = 2'd1;
  localparam logic [1:0] OP_WRITE   = 2'd2;

  // Command kinds after classification.
  localparam logic [1:0] CMD_NONE    = 2'd0;
  localparam logic [1:0] CMD_TO_MV   = 2'd1;
  localparam logic [1:0] CMD_TO_CODE = 2'd2;
  localparam logic [1:0] CMD_WRITE   = 2'd3;

  typedef struct packed {
    logic [1:0]        op;
    logic [DATA_W-1:0] value;
    logic [IDX_W-1:0]  point_index;
    logic [DATA_W-1:0] point_code;
    logic [DATA_W-1:0] point_millivolts;
  } in_word_t;

  typedef struct packed {
    logic [DATA_W-1:0] converted;
    logic              in_range;
  } out_word_t;

  typedef struct packed {
    logic [1:0]        kind;
    logic [DATA_W-1:0] value;
    logic [IDX_W-1:0]  point_index;
    logic [DATA_W-1:0] point_code;
    logic [DATA_W-1:0] point_millivolts;
  } cmd_t;

  // Factory calibration table as {code, millivolts}; entries past the
  // fourteenth repeat the last point.
  function automatic logic [POINT_W-1:0] reset_point(input logic [PIDX_W-1:0] idx);
    logic [POINT_W-1:0] pt;
    case (idx)
      0:       pt = {12'd3123, 12'd2000};
      1:       pt = {12'd3207, 12'd2100};
      2:       pt = {12'd3301, 12'd2200};
      3:       pt = {12'd3361, 12'd2270};
      4:       pt = {12'd3434, 12'd2350};
      5:       pt = {12'd3515, 12'd2430};
      6:       pt = {12'd3598, 12'd2520};
      7:       pt = {12'd3682, 12'd2600};
      8:       pt = {12'd3745, 12'd2680};
      9:       pt = {12'd3825, 12'd2760};
      10:      pt = {12'd3867, 12'd2800};
      11:      pt = {12'd3891, 12'd2900};
      12:      pt = {12'd3986, 12'd3000};
      default: pt = {12'd4095, 12'd3300};
    endcase
    return pt;
  endfunction

endpackage

[rtl/core/plc_ram.sv]
module plc_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 14
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

[rtl/core/plc_front.sv]
module plc_front
  import plc_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  in_word_t in_word,
  output logic     full,
  output logic     cmd_valid,
  output cmd_t     cmd_word,
  input  logic     cmd_pop
);

  cmd_t       q_mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       do_push, do_pop;
  cmd_t       cls;

  // Classify the request; out-of-table writes and unknown opcodes become CMD_NONE.
  always_comb begin
    cls.value            = in_word.value;
    cls.point_index      = in_word.point_index;
    cls.point_code       = in_word.point_code;
    cls.point_millivolts = in_word.point_millivolts;
    case (in_word.op)
      OP_TO_MV:   cls.kind = CMD_TO_MV;
      OP_TO_CODE: cls.kind = CMD_TO_CODE;
      OP_WRITE:   cls.kind = (int'(in_word.point_index) < TABLE_POINTS) ? CMD_WRITE : CMD_NONE;
      default:    cls.kind = CMD_NONE;
    endcase
  end

  assign full      = (cnt_r == 2'd2);
  assign cmd_valid = (cnt_r != 2'd0);
  assign cmd_word  = q_mem_r[rd_ptr_r];
  assign do_push   = push && !full;
  assign do_pop    = cmd_pop && cmd_valid;

  always_comb begin
    wr_ptr_nxt = do_push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop ? !rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      q_mem_r[wr_ptr_r] <= cls;
    end
  end

endmodule

[rtl/core/plc_back.sv]
`include "piecewise_linear_calibration_assert.svh"

module plc_back
  import plc_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      cmd_valid,
  input  cmd_t      cmd_word,
  output logic      cmd_pop,
  input  logic      res_full,
  output logic      res_push,
  output out_word_t res_word
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_WRITE = 3'd1;
  localparam logic [2:0] S_SCAN  = 3'd2;
  localparam logic [2:0] S_MUL   = 3'd3;
  localparam logic [2:0] S_DIV   = 3'd4;
  localparam logic [2:0] S_FIX   = 3'd5;
  localparam logic [2:0] S_EMIT  = 3'd6;

  logic [2:0]              state_r, state_nxt;
  logic [TABLE_POINTS-1:0] valid_r, valid_nxt;
  cmd_t                    cmd_r, cmd_nxt;
  logic [CNT_W-1:0]        cnt_r, cnt_nxt;
  logic [DIV_CNT_W-1:0]    div_cnt_r, div_cnt_nxt;
  logic                    rd_valid_r, rd_valid_nxt;
  logic [PIDX_W-1:0]       rd_addr_r, rd_addr_nxt;
  logic [DATA_W-1:0]       key0_r, key0_nxt;
  logic [DATA_W-1:0]       prev_key_r, prev_key_nxt;
  logic [DATA_W-1:0]       prev_val_r, prev_val_nxt;
  logic                    found_r, found_nxt;
  logic                    hit_r, hit_nxt;
  logic [DATA_W-1:0]       lkey_r, lkey_nxt;
  logic [DATA_W-1:0]       lval_r, lval_nxt;
  logic [DATA_W-1:0]       rkey_r, rkey_nxt;
  logic [DATA_W-1:0]       rval_r, rval_nxt;
  logic [DATA_W-1:0]       rem_r, rem_nxt;
  logic [DATA_W-1:0]       q_r, q_nxt;
  logic [DATA_W-1:0]       span_r, span_nxt;
  logic                    neg_r, neg_nxt;
  out_word_t               res_r, res_nxt;

  logic                    ram_we;
  logic [PIDX_W-1:0]       ram_waddr;
  logic [PIDX_W-1:0]       ram_raddr;
  logic [POINT_W-1:0]      ram_rdata;
  logic [POINT_W-1:0]      point;
  logic [DATA_W-1:0]       key, val;
  logic                    first_pt, last_pt, bracket;
  logic [DATA_W-1:0]       off, span, mag;
  logic [DATA_W:0]         rise;
  logic [PROD_W-1:0]       prod;
  logic [DATA_W:0]         trial, diff;
  logic                    ge;

  plc_ram #(
    .WIDTH (POINT_W),
    .DEPTH (TABLE_POINTS)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata ({cmd_r.point_code, cmd_r.point_millivolts}),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // An entry never written since reset reads as its factory value.
  assign point     = rd_valid_r ? ram_rdata : reset_point(rd_addr_r);
  assign key       = (cmd_r.kind == CMD_TO_MV) ? point[POINT_W-1:DATA_W] : point[DATA_W-1:0];
  assign val       = (cmd_r.kind == CMD_TO_MV) ? point[DATA_W-1:0] : point[POINT_W-1:DATA_W];
  assign ram_waddr = PIDX_W'(cmd_r.point_index);
  assign ram_raddr = (cnt_r < CNT_W'(TABLE_POINTS)) ? cnt_r[PIDX_W-1:0] : '0;
  assign first_pt  = (cnt_r == CNT_W'(1));
  assign last_pt   = (cnt_r == CNT_W'(TABLE_POINTS));
  assign bracket   = !first_pt && (prev_key_r <= cmd_r.value) && (key >= cmd_r.value);

  assign off  = cmd_r.value - lkey_r;
  assign span = rkey_r - lkey_r;
  assign rise = {1'b0, rval_r} - {1'b0, lval_r};
  assign mag  = rise[DATA_W] ? (lval_r - rval_r) : (rval_r - lval_r);
  assign prod = PROD_W'(off) * PROD_W'(mag);

  assign trial = {rem_r, q_r[DATA_W-1]};
  assign diff  = trial - {1'b0, span_r};
  assign ge    = (trial >= {1'b0, span_r});

  always_comb begin
    state_nxt    = state_r;
    valid_nxt    = valid_r;
    cmd_nxt      = cmd_r;
    cnt_nxt      = cnt_r;
    div_cnt_nxt  = div_cnt_r;
    rd_valid_nxt = valid_r[ram_raddr];
    rd_addr_nxt  = ram_raddr;
    key0_nxt     = key0_r;
    prev_key_nxt = prev_key_r;
    prev_val_nxt = prev_val_r;
    found_nxt    = found_r;
    hit_nxt      = hit_r;
    lkey_nxt     = lkey_r;
    lval_nxt     = lval_r;
    rkey_nxt     = rkey_r;
    rval_nxt     = rval_r;
    rem_nxt      = rem_r;
    q_nxt        = q_r;
    span_nxt     = span_r;
    neg_nxt      = neg_r;
    res_nxt      = res_r;
    cmd_pop      = 1'b0;
    res_push     = 1'b0;
    ram_we       = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (cmd_valid) begin
          cmd_pop = 1'b1;
          cmd_nxt = cmd_word;
          res_nxt = '0;
          case (cmd_word.kind)
            CMD_WRITE: state_nxt = S_WRITE;
            CMD_TO_MV, CMD_TO_CODE: begin
              cnt_nxt   = '0;
              found_nxt = 1'b0;
              state_nxt = S_SCAN;
            end
            default: state_nxt = S_EMIT;
          endcase
        end
      end

      S_WRITE: begin
        ram_we               = 1'b1;
        valid_nxt[ram_waddr] = 1'b1;
        state_nxt            = S_EMIT;
      end

      S_SCAN: begin
        // Each cycle reads the next point and tests the segment ending in
        // the point read the cycle before.
        cnt_nxt = cnt_r + CNT_W'(1);
        if (cnt_r != '0) begin
          if (first_pt) begin
            key0_nxt = key;
          end
          if (bracket && !found_r) begin
            found_nxt = 1'b1;
            lkey_nxt  = prev_key_r;
            lval_nxt  = prev_val_r;
            rkey_nxt  = key;
            rval_nxt  = val;
          end
          prev_key_nxt = key;
          prev_val_nxt = val;
          if (last_pt) begin
            hit_nxt   = (cmd_r.value >= key0_r) && (cmd_r.value <= key);
            state_nxt = S_MUL;
          end
        end
      end

      S_MUL: begin
        span_nxt    = span;
        neg_nxt     = rise[DATA_W];
        rem_nxt     = prod[PROD_W-1:DATA_W];
        q_nxt       = prod[DATA_W-1:0];
        div_cnt_nxt = '0;
        if (!hit_r) begin
          res_nxt   = '0;
          state_nxt = S_EMIT;
        end else if (!found_r) begin
          res_nxt.converted = '0;
          res_nxt.in_range  = 1'b1;
          state_nxt         = S_EMIT;
        end else if (span == '0) begin
          res_nxt.converted = lval_r;
          res_nxt.in_range  = 1'b1;
          state_nxt         = S_EMIT;
        end else begin
          state_nxt = S_DIV;
        end
      end

      S_DIV: begin
        rem_nxt = ge ? diff[DATA_W-1:0] : trial[DATA_W-1:0];
        q_nxt   = {q_r[DATA_W-2:0], ge};
        if (div_cnt_r == DIV_CNT_W'(DIV_STEPS - 1)) begin
          state_nxt = S_FIX;
        end else begin
          div_cnt_nxt = div_cnt_r + DIV_CNT_W'(1);
        end
      end

      S_FIX: begin
        res_nxt.converted = neg_r ? (lval_r - q_r) : (lval_r + q_r);
        res_nxt.in_range  = 1'b1;
        state_nxt         = S_EMIT;
      end

      S_EMIT: begin
        if (!res_full) begin
          res_push  = 1'b1;
          state_nxt = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      valid_r <= '0;
    end else begin
      state_r <= state_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r      <= cmd_nxt;
    cnt_r      <= cnt_nxt;
    div_cnt_r  <= div_cnt_nxt;
    rd_valid_r <= rd_valid_nxt;
    rd_addr_r  <= rd_addr_nxt;
    key0_r     <= key0_nxt;
    prev_key_r <= prev_key_nxt;
    prev_val_r <= prev_val_nxt;
    found_r    <= found_nxt;
    hit_r      <= hit_nxt;
    lkey_r     <= lkey_nxt;
    lval_r     <= lval_nxt;
    rkey_r     <= rkey_nxt;
    rval_r     <= rval_nxt;
    rem_r      <= rem_nxt;
    q_r        <= q_nxt;
    span_r     <= span_nxt;
    neg_r      <= neg_nxt;
    res_r      <= res_nxt;
  end

  assign res_word = res_r;

  `PLC_ASSERT(a_div_rem_bound, (state_r == S_DIV) |-> (rem_r < span_r), "divider remainder not below divisor")
  `PLC_ASSERT(a_div_only_found, (state_r == S_DIV) |-> (found_r && hit_r && (span_r != '0)), "division without a bracketing segment")
  `PLC_NEVER(a_scan_bound, (state_r == S_SCAN) && (cnt_r > CNT_W'(TABLE_POINTS)), "segment scan ran past the table")

endmodule

[rtl/core/piecewise_linear_calibration.sv]
// Channel  Direction  Handshake        Word
// input    in         push / full      in_word  (op, value, point fields)
// result   out        pop / empty      out_word (converted, in_range)
//
// A conversion runs a table scan at one read per cycle, one multiply, twelve
// restoring divider steps and control. A table write passes through the idle,
// write and emit states, and a null request through idle and emit alone.
// Reset is synchronous and active low; per-entry valid bits restore the factory
// table at once, so no clearing pass is needed.
// Two-word command and result queues let requests arrive while a result waits.
`include "piecewise_linear_calibration_assert.svh"

module piecewise_linear_calibration
  import plc_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  in_word_t  in_word,
  output logic      full,
  output logic      empty,
  input  logic      pop,
  output out_word_t out_word
);

  logic      cmd_valid;
  cmd_t      cmd_word;
  logic      cmd_pop;
  logic      res_push;
  logic      res_full;
  out_word_t res_word;

  // Result queue: two words, so the back end can finish the next request
  // while the consumer has not yet popped the last one.
  out_word_t  res_mem_r [2];
  logic       res_wr_r, res_wr_nxt;
  logic       res_rd_r, res_rd_nxt;
  logic [1:0] res_cnt_r, res_cnt_nxt;
  logic       do_pop;

  // The front end classifies each request and queues it as a command.
  plc_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .in_word   (in_word),
    .full      (full),
    .cmd_valid (cmd_valid),
    .cmd_word  (cmd_word),
    .cmd_pop   (cmd_pop)
  );

  // The back end owns the table and carries out searches, divisions and writes.
  plc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd_word  (cmd_word),
    .cmd_pop   (cmd_pop),
    .res_full  (res_full),
    .res_push  (res_push),
    .res_word  (res_word)
  );

  assign res_full = (res_cnt_r == 2'd2);
  assign empty    = (res_cnt_r == 2'd0);
  assign out_word = res_mem_r[res_rd_r];
  assign do_pop   = pop && !empty;

  always_comb begin
    res_wr_nxt  = res_push ? !res_wr_r : res_wr_r;
    res_rd_nxt  = do_pop ? !res_rd_r : res_rd_r;
    res_cnt_nxt = res_cnt_r + {1'b0, res_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_wr_r  <= 1'b0;
      res_rd_r  <= 1'b0;
      res_cnt_r <= 2'd0;
    end else begin
      res_wr_r  <= res_wr_nxt;
      res_rd_r  <= res_rd_nxt;
      res_cnt_r <= res_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_push) begin
      res_mem_r[res_wr_r] <= res_word;
    end
  end

  `PLC_NEVER(a_res_overflow, res_cnt_r == 2'd3, "result queue count out of range")

endmodule
